>>> hdl/icrpg_pkg.sv
package icrpg_pkg;

  localparam int PAD_ROWS    = 8;
  localparam int PANEL_ROWS  = 16;
  localparam int PANEL_COLS  = 48;
  localparam int FRAMES      = 24;

  localparam int OFF_START   = 6;
  localparam int OFF_ROW_LAG = 2;

  localparam logic [7:0] OFFSET_RESET = 8'd10;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] PIX_IGNORE = 2'd0;
  localparam logic [1:0] PIX_ON     = 2'd1;
  localparam logic [1:0] PIX_OFF    = 2'd2;

  localparam logic [4:0] LAST_SENSOR_ROW = 5'(PAD_ROWS - 1);
  localparam logic [4:0] EDGE_ROW        = 5'(PANEL_ROWS);
  localparam logic [4:0] LAST_FRAME      = 5'(FRAMES - 1);
  localparam logic [5:0] ROW_LIMIT       = 6'(PANEL_ROWS);
  localparam logic [8:0] COL_LIMIT       = 9'(PANEL_COLS);

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] sensor_value;
    logic [7:0] sensor_min;
    logic [4:0] row;
    logic [5:0] col;
  } icrpg_in_t;

  typedef struct packed {
    logic       active;
    logic [1:0] pixel_code;
  } icrpg_out_t;

  typedef struct packed {
    logic       running;
    logic [4:0] origin_row;
    logic [7:0] origin_col;
    logic [4:0] frame;
  } icrpg_state_t;

  // frame / 3 for frame < 32
  function automatic logic [3:0] div3(input logic [4:0] f);
    logic [8:0] p;
    p = {f, 3'b000} + {2'b00, f, 1'b0} + {4'b0000, f};
    return p[8:5];
  endfunction

  function automatic logic hits(input logic [4:0] qr, input logic [5:0] qc,
                                input logic [4:0] orow, input logic [7:0] ocol,
                                input logic [3:0] dv, input logic [4:0] dh);
    logic [4:0] up_row;
    logic [5:0] dn_row;
    logic [7:0] lt_col;
    logic [8:0] rt_col;
    logic       up, dn, lt, rt;
    up_row = orow - {1'b0, dv};
    dn_row = {1'b0, orow} + {2'b00, dv};
    lt_col = ocol - {3'b000, dh};
    rt_col = {1'b0, ocol} + {4'b0000, dh};
    up = (orow >= {1'b0, dv}) && (qr == up_row) && ({2'b00, qc} == ocol);
    dn = (dn_row < ROW_LIMIT) && ({1'b0, qr} == dn_row) && ({2'b00, qc} == ocol);
    lt = (ocol >= {3'b000, dh}) && (qr == orow) && ({2'b00, qc} == lt_col);
    rt = (rt_col < COL_LIMIT) && (qr == orow) && ({3'b000, qc} == rt_col);
    return up | dn | lt | rt;
  endfunction

endpackage

>>> hdl/icrpg_evt.sv
module icrpg_evt
  import icrpg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data,
  input  logic         step,
  input  icrpg_in_t    req,
  output icrpg_state_t st,
  output logic         running_nxt
);

  logic [7:0]   offset_r;
  icrpg_state_t st_r, st_nxt;
  logic [7:0]   limit;
  logic [9:0]   col13;

  assign limit = req.sensor_min + offset_r;
  assign col13 = {1'b0, req.col, 3'b000} + {2'b00, req.col, 2'b00} + {4'b0000, req.col};

  always_comb begin
    st_nxt = st_r;
    case (req.operation)
      OP_SAMPLE: begin
        if (req.sensor_value <= limit) begin
          st_nxt.running    = 1'b1;
          st_nxt.origin_row = (req.row == LAST_SENSOR_ROW) ? EDGE_ROW : req.row;
          st_nxt.origin_col = col13[9:2];
          st_nxt.frame      = '0;
        end
      end
      OP_TICK: begin
        if (st_r.frame < LAST_FRAME) begin
          st_nxt.frame = st_r.frame + 5'd1;
        end else begin
          st_nxt.running = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
      st_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        offset_r <= cfg_wr_data;
      end
      if (step) begin
        st_r <= st_nxt;
      end
    end
  end

  assign st          = st_r;
  assign running_nxt = st_nxt.running;

endmodule

>>> hdl/icrpg_pix.sv
module icrpg_pix
  import icrpg_pkg::*;
(
  input  icrpg_state_t st,
  input  logic [4:0]   qr,
  input  logic [5:0]   qc,
  output logic [1:0]   code
);

  logic [3:0] v;
  logic       on_hit, off_hit;

  assign v       = div3(st.frame);
  assign on_hit  = hits(qr, qc, st.origin_row, st.origin_col, v, st.frame);
  assign off_hit = (st.frame >= 5'(OFF_START)) &&
                   hits(qr, qc, st.origin_row, st.origin_col,
                        v - 4'(OFF_ROW_LAG), st.frame - 5'(OFF_START));

  always_comb begin
    code = PIX_IGNORE;
    if (on_hit)  code = PIX_ON;
    if (off_hit) code = PIX_OFF;
  end

endmodule

>>> hdl/impact_cross_ripple_pixel_gen_core.sv
// channel   ports                            request
// input     in_valid / in_stall / in_data    operation, sensor fields, row, col
// result    out_valid / out_stall / out_data active, pixel_code
// config    cfg_wr_en / cfg_wr_data          trigger_offset
//
// One request per cycle unless stalled; a request passes the input register,
// then the result register. State updates in the input-to-result stage.
// Synchronous active-low reset; trigger_offset resets to 10, state to zero.
// in_stall rises only when the input register is full and the result register
// is held by out_stall.
module impact_cross_ripple_pixel_gen_core
  import icrpg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  icrpg_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output icrpg_out_t out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic         s1_valid_r;
  icrpg_in_t    s1_data_r;
  logic         out_valid_r;
  icrpg_out_t   out_data_r, out_data_nxt;
  logic         adv;
  icrpg_state_t st;
  logic         running_nxt;
  logic [1:0]   code;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  icrpg_evt u_evt (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (adv),
    .req         (s1_data_r),
    .st          (st),
    .running_nxt (running_nxt)
  );

  icrpg_pix u_pix (
    .st   (st),
    .qr   (s1_data_r.row),
    .qc   (s1_data_r.col),
    .code (code)
  );

  always_comb begin
    out_data_nxt.active     = running_nxt;
    out_data_nxt.pixel_code = (s1_data_r.operation == OP_QUERY) ? code : PIX_IGNORE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("in_stall without a blocked request");

  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("result register not loaded");

  a_code_query_only: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_data_r.operation != OP_QUERY) |=> (out_data_r.pixel_code == PIX_IGNORE))
    else $error("pixel code on a non-query request");

  a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st.frame <= LAST_FRAME)
    else $error("frame beyond last");

  a_last_tick_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_data_r.operation == OP_TICK && st.frame == LAST_FRAME)
      |=> !out_data_r.active)
    else $error("still active after last frame");

endmodule
